// ===== hw/rtl/mtc_pkg.sv =====
package mtc_pkg;

  localparam int TIME_WIDTH  = 48;
  localparam int COUNT_WIDTH = 32;

  typedef logic signed [TIME_WIDTH-1:0] time_t;
  typedef logic [TIME_WIDTH-2:0]        length_t;
  typedef logic [COUNT_WIDTH-1:0]       count_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_PAUSE  = 3'd2,
    OP_RESUME = 3'd3,
    OP_SEEK   = 3'd4,
    OP_DUE    = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    WAIT_PENDING = 2'd0,
    WAIT_DUE     = 2'd1,
    WAIT_STALE   = 2'd2
  } wait_t;

  typedef enum logic {
    CFG_START_TIME  = 1'b0,
    CFG_PLAY_LENGTH = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [2:0] opcode;
    time_t      target_pts;
    count_t     generation_tag;
  } item_t;

  typedef struct packed {
    logic   accepted;
    wait_t  wait_status;
    logic   started;
    logic   playing;
    time_t  media_pts;
    count_t generation;
    count_t revision;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

// ===== hw/rtl/mtc_in_reg.sv =====
module mtc_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mtc_pkg::item_t in_item,
  input  logic          take,
  output mtc_pkg::stage_t stage
);
  import mtc_pkg::*;

  logic  full;
  item_t item;

  assign in_ready    = !full || take;
  assign stage.valid = full;
  assign stage.item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (full && !take) |=> $stable(item))
    else $error("held item changed while waiting");

endmodule

// ===== hw/rtl/mtc_core.sv =====
module mtc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic             cfg_index,
  input  mtc_pkg::time_t   cfg_data,
  input  mtc_pkg::stage_t  stage,
  output logic             take,
  output logic             out_valid,
  input  logic             out_ready,
  output mtc_pkg::result_t result
);
  import mtc_pkg::*;

  time_t   start_time;
  length_t play_length;

  logic    is_started;
  logic    is_playing;
  time_t   current_time;
  time_t   latched_start;
  time_t   latched_end;
  count_t  seek_count;
  count_t  change_count;

  logic    is_started_next;
  logic    is_playing_next;
  time_t   current_time_next;
  time_t   latched_start_next;
  time_t   latched_end_next;
  count_t  seek_count_next;
  count_t  change_count_next;
  logic    accepted_next;
  wait_t   wait_next;

  logic [TIME_WIDTH:0] start_sum;
  logic    start_over;
  time_t   end_cand;
  opcode_t op;
  time_t   target;

  assign take = stage.valid && (!out_valid || out_ready);

  assign op         = opcode_t'(stage.item.opcode);
  assign target     = stage.item.target_pts;
  assign start_sum  = {start_time[TIME_WIDTH-1], start_time} + {2'b00, play_length};
  assign start_over = !start_sum[TIME_WIDTH] && start_sum[TIME_WIDTH-1];
  assign end_cand   = start_sum[TIME_WIDTH-1:0];

  always_comb begin
    is_started_next    = is_started;
    is_playing_next    = is_playing;
    current_time_next  = current_time;
    latched_start_next = latched_start;
    latched_end_next   = latched_end;
    seek_count_next    = seek_count;
    change_count_next  = change_count;
    accepted_next      = 1'b0;
    wait_next          = WAIT_PENDING;
    case (op)
      OP_TICK: begin
        accepted_next = 1'b1;
        if (is_started && is_playing && (current_time < latched_end)) begin
          current_time_next = current_time + time_t'(1);
        end
      end
      OP_START: begin
        if (start_over) begin
          accepted_next = 1'b0;
        end else if (is_started) begin
          accepted_next = (latched_start == start_time) && (latched_end == end_cand);
        end else begin
          accepted_next      = 1'b1;
          is_started_next    = 1'b1;
          is_playing_next    = 1'b1;
          latched_start_next = start_time;
          latched_end_next   = end_cand;
          current_time_next  = start_time;
          seek_count_next    = '0;
          change_count_next  = '0;
        end
      end
      OP_PAUSE: begin
        if (is_started && is_playing && (change_count != COUNT_MAX)) begin
          accepted_next     = 1'b1;
          is_playing_next   = 1'b0;
          change_count_next = change_count + count_t'(1);
        end
      end
      OP_RESUME: begin
        if (is_started && !is_playing && (change_count != COUNT_MAX)) begin
          accepted_next     = 1'b1;
          is_playing_next   = 1'b1;
          change_count_next = change_count + count_t'(1);
        end
      end
      OP_SEEK: begin
        if (is_started && (target >= latched_start) && (target <= latched_end) &&
            (seek_count != COUNT_MAX) && (change_count != COUNT_MAX)) begin
          accepted_next     = 1'b1;
          current_time_next = target;
          seek_count_next   = seek_count + count_t'(1);
          change_count_next = change_count + count_t'(1);
        end
      end
      OP_DUE: begin
        if (!is_started || (stage.item.generation_tag != seek_count)) begin
          wait_next = WAIT_STALE;
        end else if ((target <= current_time) || (current_time == latched_end)) begin
          wait_next = WAIT_DUE;
        end else begin
          wait_next = WAIT_PENDING;
        end
        accepted_next = (wait_next != WAIT_STALE);
      end
      default: begin
        accepted_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time  <= '0;
      play_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_START_TIME:  start_time  <= cfg_data;
        CFG_PLAY_LENGTH: play_length <= cfg_data[TIME_WIDTH-2:0];
        default:         start_time  <= start_time;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_started    <= 1'b0;
      is_playing    <= 1'b0;
      current_time  <= '0;
      latched_start <= '0;
      latched_end   <= '0;
      seek_count    <= '0;
      change_count  <= '0;
      out_valid     <= 1'b0;
    end else if (take) begin
      is_started    <= is_started_next;
      is_playing    <= is_playing_next;
      current_time  <= current_time_next;
      latched_start <= latched_start_next;
      latched_end   <= latched_end_next;
      seek_count    <= seek_count_next;
      change_count  <= change_count_next;
      out_valid     <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.accepted    <= accepted_next;
      result.wait_status <= wait_next;
      result.started     <= is_started_next;
      result.playing     <= is_playing_next;
      result.media_pts   <= current_time_next;
      result.generation  <= seek_count_next;
      result.revision    <= change_count_next;
    end
  end

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !is_started |-> (!is_playing && seek_count == '0 && change_count == '0))
    else $error("state moved before start");

  a_seek_le_change: assert property (@(posedge clk) disable iff (rst)
    seek_count <= change_count)
    else $error("generation ran ahead of revision");

  a_time_bounds: assert property (@(posedge clk) disable iff (rst)
    is_started |-> (current_time >= latched_start && current_time <= latched_end))
    else $error("current time left the latched bounds");

  a_stale_rejected: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.wait_status == WAIT_STALE) |-> !result.accepted)
    else $error("stale due check reported as accepted");

  a_result_snapshot: assert property (@(posedge clk) disable iff (rst)
    take |=> (result.started == is_started && result.media_pts == current_time &&
              result.generation == seek_count && result.revision == change_count))
    else $error("result snapshot differs from state");

endmodule

// ===== hw/rtl/media_timeline_clock_core.sv =====
// Channel  Handshake              Payload
// cfg      cfg_valid / cfg_ready  cfg_index (0 start_time, 1 play_length), cfg_data
// in       in_valid / in_ready    opcode, target_pts, generation_tag
// out      out_valid / out_ready  accepted, wait_status, started, playing,
//                                 media_pts, generation, revision
//
// One item per cycle while the result is not stalled; from input transfer to
// result the item passes the input register, then the state update and result
// register.
// The state update is one compare, add and clamp between those two registers.
// Synchronous reset clears state, configuration and both valid flags.
// A stalled result holds the input register; in_ready stays high while either
// the input register is empty or its item moves on in the same cycle.
module media_timeline_clock_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [mtc_pkg::TIME_WIDTH-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           opcode,
  input  logic signed [mtc_pkg::TIME_WIDTH-1:0] target_pts,
  input  logic [mtc_pkg::COUNT_WIDTH-1:0]      generation_tag,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 accepted,
  output logic [1:0]                           wait_status,
  output logic                                 started,
  output logic                                 playing,
  output logic signed [mtc_pkg::TIME_WIDTH-1:0] media_pts,
  output logic [mtc_pkg::COUNT_WIDTH-1:0]      generation,
  output logic [mtc_pkg::COUNT_WIDTH-1:0]      revision
);
  import mtc_pkg::*;

  item_t   in_item;
  stage_t  stage;
  logic    take;
  result_t result;

  assign cfg_ready = 1'b1;

  assign in_item.opcode         = opcode;
  assign in_item.target_pts     = target_pts;
  assign in_item.generation_tag = generation_tag;

  mtc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .stage    (stage)
  );

  mtc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign accepted    = result.accepted;
  assign wait_status = result.wait_status;
  assign started     = result.started;
  assign playing     = result.playing;
  assign media_pts   = result.media_pts;
  assign generation  = result.generation;
  assign revision    = result.revision;

endmodule
